// ===== rtl/heap_file_record_placer_defines.svh =====
// Assertion macros shared by the heap file record placer checkers.
`ifndef HEAP_FILE_RECORD_PLACER_DEFINES_SVH
`define HEAP_FILE_RECORD_PLACER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HFRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HFRP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hfrp_pkg.sv =====
// Shared constants, types and codes of the heap file record placer.
`default_nettype none

package hfrp_pkg;

    // Heap file geometry
    localparam int MAX_PAGES      = 16;
    localparam int MAX_SLOTS      = 64;
    localparam int KEY_BITS       = 32;
    localparam int PAGE_HDR_BYTES = 16;
    localparam int SLOT_OVH_BYTES = 4;

    // Port field widths
    localparam int MODE_W       = 2;
    localparam int BYTES_W      = 16;
    localparam int KEY_W        = 32;
    localparam int PAGE_FIELD_W = 4;
    localparam int SLOT_FIELD_W = 6;
    localparam int COUNT_W      = 7;

    localparam logic [BYTES_W-1:0] PAGE_BYTES_RESET = 16'd4096;

    // Internal widths
    localparam int PAGE_IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PAGE_CNT_W = $clog2(MAX_PAGES + 1);
    localparam int SLOT_IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int REC_CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int MEM_ADDR_W = PAGE_IDX_W + SLOT_IDX_W;
    localparam int MEM_DEPTH  = 1 << MEM_ADDR_W;
    localparam int NEED_W     = BYTES_W + 1;
    localparam int DIFF_W     = BYTES_W + 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_REPORT = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_NEW,
        ST_INS_PLACE,
        ST_SRCH,
        ST_EMIT,
        ST_RPT_HEAD,
        ST_RPT_PAGE
    } state_t;

    // Sequencer to page table
    typedef struct packed {
        logic                  create;
        logic                  place;
        logic [PAGE_IDX_W-1:0] page;
        logic [NEED_W-1:0]     need;
    } pt_cmd_t;

    // Page table to sequencer
    typedef struct packed {
        logic                  fits;
        logic [REC_CNT_W-1:0]  rec_cnt;
        logic [PAGE_CNT_W-1:0] pages;
    } pt_stat_t;

    // Sequencer to key memory
    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [MEM_ADDR_W-1:0] addr;
        logic [KEY_BITS-1:0]   wdata;
    } km_cmd_t;

    // One result beat
    typedef struct packed {
        logic                    ok;
        logic [PAGE_FIELD_W-1:0] page;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [COUNT_W-1:0]      count;
        logic                    last;
    } beat_t;

endpackage

`default_nettype wire

// ===== rtl/hfrp_key_mem.sv =====
// Stored key memory: one write and one registered read per cycle.
`default_nettype none

module hfrp_key_mem
(
    input  wire logic                          clk,
    input  wire hfrp_pkg::km_cmd_t             cmd,
    output logic [hfrp_pkg::KEY_BITS-1:0]      rd_data
);

    logic [hfrp_pkg::KEY_BITS-1:0] key_ram_reg [hfrp_pkg::MEM_DEPTH];
    logic [hfrp_pkg::KEY_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            key_ram_reg[cmd.addr] <= cmd.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.re)
        begin
            rd_data_reg <= key_ram_reg[cmd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/hfrp_page_tbl.sv =====
// Page table: free bytes and record count per page, page count, shared subtractor.
`default_nettype none

module hfrp_page_tbl
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [hfrp_pkg::BYTES_W-1:0]  page_bytes,
    input  wire hfrp_pkg::pt_cmd_t             cmd,
    output hfrp_pkg::pt_stat_t                 stat
);

    logic [hfrp_pkg::BYTES_W-1:0]    free_bytes_reg [hfrp_pkg::MAX_PAGES];
    logic [hfrp_pkg::REC_CNT_W-1:0]  rec_cnt_reg    [hfrp_pkg::MAX_PAGES];
    logic [hfrp_pkg::PAGE_CNT_W-1:0] pages_reg;
    logic [hfrp_pkg::PAGE_CNT_W-1:0] pages_next;

    logic [hfrp_pkg::BYTES_W-1:0]    opa;
    logic [hfrp_pkg::NEED_W-1:0]     opb;
    logic [hfrp_pkg::DIFF_W-1:0]     diff;
    logic                            ge;

    // One subtractor: new page header cut, or fit test and space charge
    always_comb
    begin
        opa  = cmd.create ? page_bytes : free_bytes_reg[cmd.page];
        opb  = cmd.create ? hfrp_pkg::NEED_W'(hfrp_pkg::PAGE_HDR_BYTES) : cmd.need;
        diff = {2'b00, opa} - {1'b0, opb};
        ge   = ~diff[hfrp_pkg::DIFF_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.create)
        begin
            free_bytes_reg[cmd.page] <= ge ? diff[hfrp_pkg::BYTES_W-1:0] : '0;
            rec_cnt_reg[cmd.page]    <= '0;
        end
        else if (cmd.place)
        begin
            free_bytes_reg[cmd.page] <= diff[hfrp_pkg::BYTES_W-1:0];
            rec_cnt_reg[cmd.page]    <= rec_cnt_reg[cmd.page] + hfrp_pkg::REC_CNT_W'(1);
        end
    end

    assign pages_next = cmd.create ? pages_reg + hfrp_pkg::PAGE_CNT_W'(1) : pages_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg <= '0;
        end
        else
        begin
            pages_reg <= pages_next;
        end
    end

    always_comb
    begin
        stat.fits    = ge;
        stat.rec_cnt = rec_cnt_reg[cmd.page];
        stat.pages   = pages_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/hfrp_ctrl.sv =====
// Sequencer: walks pages and slots for insert, search and report.
`default_nettype none

module hfrp_ctrl
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic [hfrp_pkg::MODE_W-1:0]   mode,
    input  wire logic [hfrp_pkg::BYTES_W-1:0]  record_bytes,
    input  wire logic signed [hfrp_pkg::KEY_W-1:0] key,
    output logic                               req_stall,
    input  wire logic                          out_ready,
    input  wire hfrp_pkg::pt_stat_t            pt_stat,
    input  wire logic [hfrp_pkg::KEY_BITS-1:0] rd_data,
    output hfrp_pkg::pt_cmd_t                  pt_cmd,
    output hfrp_pkg::km_cmd_t                  km_cmd,
    output logic                               emit,
    output hfrp_pkg::beat_t                    beat
);

    hfrp_pkg::state_t                state_reg, state_next;
    logic [hfrp_pkg::NEED_W-1:0]     need_reg, need_next;
    logic [hfrp_pkg::KEY_BITS-1:0]   key_reg, key_next;
    logic [hfrp_pkg::PAGE_CNT_W-1:0] ptr_reg, ptr_next;
    logic [hfrp_pkg::REC_CNT_W-1:0]  slot_reg, slot_next;
    logic                            pend_reg, pend_next;
    logic [hfrp_pkg::PAGE_IDX_W-1:0] tag_page_reg, tag_page_next;
    logic [hfrp_pkg::SLOT_IDX_W-1:0] tag_slot_reg, tag_slot_next;
    logic                            res_ok_reg, res_ok_next;
    logic [hfrp_pkg::PAGE_IDX_W-1:0] res_page_reg, res_page_next;
    logic [hfrp_pkg::SLOT_IDX_W-1:0] res_slot_reg, res_slot_next;

    logic [hfrp_pkg::PAGE_CNT_W-1:0] ptr_inc;
    logic [hfrp_pkg::REC_CNT_W-1:0]  slot_inc;
    logic [hfrp_pkg::PAGE_IDX_W-1:0] ptr_idx;
    logic                            place_ok;
    logic                            hit;
    logic                            page_live;
    logic                            slot_live;
    logic                            rpt_last;

    always_comb
    begin
        ptr_inc   = ptr_reg + hfrp_pkg::PAGE_CNT_W'(1);
        slot_inc  = slot_reg + hfrp_pkg::REC_CNT_W'(1);
        ptr_idx   = ptr_reg[hfrp_pkg::PAGE_IDX_W-1:0];
        place_ok  = pt_stat.fits
                    && (pt_stat.rec_cnt < hfrp_pkg::REC_CNT_W'(hfrp_pkg::MAX_SLOTS));
        hit       = pend_reg && (rd_data == key_reg);
        page_live = ptr_reg < pt_stat.pages;
        slot_live = slot_reg < pt_stat.rec_cnt;
        rpt_last  = ptr_inc == pt_stat.pages;
    end

    // Next state
    always_comb
    begin
        state_next    = state_reg;
        need_next     = need_reg;
        key_next      = key_reg;
        ptr_next      = ptr_reg;
        slot_next     = slot_reg;
        pend_next     = pend_reg;
        tag_page_next = tag_page_reg;
        tag_slot_next = tag_slot_reg;
        res_ok_next   = res_ok_reg;
        res_page_next = res_page_reg;
        res_slot_next = res_slot_reg;

        case (state_reg)
            hfrp_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    need_next = hfrp_pkg::NEED_W'(record_bytes)
                                + hfrp_pkg::NEED_W'(hfrp_pkg::SLOT_OVH_BYTES);
                    key_next  = hfrp_pkg::KEY_BITS'($unsigned(key));
                    ptr_next  = '0;
                    slot_next = '0;
                    pend_next = 1'b0;
                    case (hfrp_pkg::mode_t'(mode))
                        hfrp_pkg::MODE_INSERT: state_next = hfrp_pkg::ST_INS_SCAN;
                        hfrp_pkg::MODE_SEARCH: state_next = hfrp_pkg::ST_SRCH;
                        hfrp_pkg::MODE_REPORT: state_next = hfrp_pkg::ST_RPT_HEAD;
                        default:               state_next = hfrp_pkg::ST_IDLE;
                    endcase
                end
            end

            hfrp_pkg::ST_INS_SCAN:
            begin
                if (!page_live)
                begin
                    if (pt_stat.pages == hfrp_pkg::PAGE_CNT_W'(hfrp_pkg::MAX_PAGES))
                    begin
                        // page table full: fail, no change
                        res_ok_next   = 1'b0;
                        res_page_next = '0;
                        res_slot_next = '0;
                        state_next    = hfrp_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = hfrp_pkg::ST_INS_NEW;
                    end
                end
                else if (pt_stat.fits)
                begin
                    state_next = hfrp_pkg::ST_INS_PLACE;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end

            hfrp_pkg::ST_INS_NEW:
            begin
                state_next = hfrp_pkg::ST_INS_PLACE;
            end

            hfrp_pkg::ST_INS_PLACE:
            begin
                res_ok_next   = place_ok;
                res_page_next = place_ok ? ptr_idx : '0;
                res_slot_next = place_ok ? pt_stat.rec_cnt[hfrp_pkg::SLOT_IDX_W-1:0] : '0;
                state_next    = hfrp_pkg::ST_EMIT;
            end

            hfrp_pkg::ST_SRCH:
            begin
                if (hit)
                begin
                    res_ok_next   = 1'b1;
                    res_page_next = tag_page_reg;
                    res_slot_next = tag_slot_reg;
                    state_next    = hfrp_pkg::ST_EMIT;
                end
                else if (page_live)
                begin
                    if (slot_live)
                    begin
                        pend_next     = 1'b1;
                        tag_page_next = ptr_idx;
                        tag_slot_next = slot_reg[hfrp_pkg::SLOT_IDX_W-1:0];
                        if (slot_inc == pt_stat.rec_cnt)
                        begin
                            ptr_next  = ptr_inc;
                            slot_next = '0;
                        end
                        else
                        begin
                            slot_next = slot_inc;
                        end
                    end
                    else
                    begin
                        // empty page: skip it
                        pend_next = 1'b0;
                        ptr_next  = ptr_inc;
                        slot_next = '0;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        res_ok_next   = 1'b0;
                        res_page_next = '0;
                        res_slot_next = '0;
                        state_next    = hfrp_pkg::ST_EMIT;
                    end
                end
            end

            hfrp_pkg::ST_EMIT:
            begin
                if (out_ready)
                begin
                    state_next = hfrp_pkg::ST_IDLE;
                end
            end

            hfrp_pkg::ST_RPT_HEAD:
            begin
                if (out_ready)
                begin
                    ptr_next   = '0;
                    state_next = (pt_stat.pages == '0) ? hfrp_pkg::ST_IDLE
                                                        : hfrp_pkg::ST_RPT_PAGE;
                end
            end

            hfrp_pkg::ST_RPT_PAGE:
            begin
                if (out_ready)
                begin
                    ptr_next = ptr_inc;
                    if (rpt_last)
                    begin
                        state_next = hfrp_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = hfrp_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        req_stall     = state_reg != hfrp_pkg::ST_IDLE;
        pt_cmd.create = 1'b0;
        pt_cmd.place  = 1'b0;
        pt_cmd.page   = ptr_idx;
        pt_cmd.need   = need_reg;
        km_cmd.we     = 1'b0;
        km_cmd.re     = 1'b0;
        km_cmd.addr   = {ptr_idx, slot_reg[hfrp_pkg::SLOT_IDX_W-1:0]};
        km_cmd.wdata  = key_reg;
        emit          = 1'b0;
        beat          = '0;

        case (state_reg)
            hfrp_pkg::ST_INS_NEW:
            begin
                pt_cmd.create = 1'b1;
            end

            hfrp_pkg::ST_INS_PLACE:
            begin
                pt_cmd.place = place_ok;
                km_cmd.we    = place_ok;
                km_cmd.addr  = {ptr_idx, pt_stat.rec_cnt[hfrp_pkg::SLOT_IDX_W-1:0]};
            end

            hfrp_pkg::ST_SRCH:
            begin
                km_cmd.re = !hit && page_live && slot_live;
            end

            hfrp_pkg::ST_EMIT:
            begin
                emit      = 1'b1;
                beat.ok   = res_ok_reg;
                beat.page = hfrp_pkg::PAGE_FIELD_W'(res_page_reg);
                beat.slot = hfrp_pkg::SLOT_FIELD_W'(res_slot_reg);
                beat.last = 1'b1;
            end

            hfrp_pkg::ST_RPT_HEAD:
            begin
                emit       = 1'b1;
                beat.ok    = 1'b1;
                beat.count = hfrp_pkg::COUNT_W'(pt_stat.pages);
                beat.last  = pt_stat.pages == '0;
            end

            hfrp_pkg::ST_RPT_PAGE:
            begin
                emit       = 1'b1;
                beat.ok    = 1'b1;
                beat.count = hfrp_pkg::COUNT_W'(pt_stat.rec_cnt);
                beat.last  = rpt_last;
            end

            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hfrp_pkg::ST_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg     <= need_next;
        key_reg      <= key_next;
        ptr_reg      <= ptr_next;
        slot_reg     <= slot_next;
        tag_page_reg <= tag_page_next;
        tag_slot_reg <= tag_slot_next;
        res_ok_reg   <= res_ok_next;
        res_page_reg <= res_page_next;
        res_slot_reg <= res_slot_next;
    end

endmodule

`default_nettype wire

// ===== rtl/heap_file_record_placer.sv =====
// Top level of the heap file record placer: config register, output register, wiring.
`default_nettype none

// First-fit record placement in a heap file of up to 16 pages of 64 slots.
// A request beat is taken only while the sequencer is idle; one shared
// subtract/compare unit in the page table does every fit test. An insert
// tests the open pages in order for the first fit, appends a page when
// none fits, and places the record if it fits and a slot is free; with
// the page table full it fails with no change. A search issues one
// key-memory read per cycle over the stored records, skips empty pages
// and compares each key read in the next cycle. A report sends
// 1 + pages_in_use result beats, one per cycle while the result side
// does not stall. Insert and search end in one result beat. An unused
// mode code is dropped with no result. The result register lets the
// next request be taken while the last result beat still waits. The
// stores come out of reset undefined and need no clearing pass: only
// pages below the page count and slots below each page's record count
// are ever read. page_bytes is sampled when a page is appended; write
// it only while the block is idle.
module heap_file_record_placer
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // Request channel
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire logic [hfrp_pkg::MODE_W-1:0]         mode,
    input  wire logic [hfrp_pkg::BYTES_W-1:0]        record_bytes,
    input  wire logic signed [hfrp_pkg::KEY_W-1:0]   key,

    // Result channel
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output logic                                     ok,
    output logic [hfrp_pkg::PAGE_FIELD_W-1:0]        page_index,
    output logic [hfrp_pkg::SLOT_FIELD_W-1:0]        slot_index,
    output logic [hfrp_pkg::COUNT_W-1:0]             count,
    output logic                                     last,

    // Page size register
    input  wire logic                                page_bytes_we,
    input  wire logic [hfrp_pkg::BYTES_W-1:0]        page_bytes_wdata
);

    logic [hfrp_pkg::BYTES_W-1:0]  page_bytes_reg;
    logic                          out_valid_reg, out_valid_next;
    hfrp_pkg::beat_t               out_beat_reg;

    logic                          out_ready;
    logic                          emit;
    hfrp_pkg::beat_t               beat;
    hfrp_pkg::pt_cmd_t             pt_cmd;
    hfrp_pkg::pt_stat_t            pt_stat;
    hfrp_pkg::km_cmd_t             km_cmd;
    logic [hfrp_pkg::KEY_BITS-1:0] rd_data;

    // Hold the page size; reset gives a 4 KiB page
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_bytes_reg <= hfrp_pkg::PAGE_BYTES_RESET;
        end
        else if (page_bytes_we)
        begin
            page_bytes_reg <= page_bytes_wdata;
        end
    end

    // Result register: free when empty or when its beat leaves this cycle
    assign out_ready      = !out_valid_reg || !rsp_stall;
    assign out_valid_next = emit ? 1'b1 : (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load a new beat only into a free register; hold it while stalled
    always_ff @(posedge clk)
    begin
        if (emit && out_ready)
        begin
            out_beat_reg <= beat;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign ok         = out_beat_reg.ok;
    assign page_index = out_beat_reg.page;
    assign slot_index = out_beat_reg.slot;
    assign count      = out_beat_reg.count;
    assign last       = out_beat_reg.last;

    // Sequencer
    hfrp_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .mode         (mode),
        .record_bytes (record_bytes),
        .key          (key),
        .req_stall    (req_stall),
        .out_ready    (out_ready),
        .pt_stat      (pt_stat),
        .rd_data      (rd_data),
        .pt_cmd       (pt_cmd),
        .km_cmd       (km_cmd),
        .emit         (emit),
        .beat         (beat)
    );

    // Page table with the shared subtract/compare unit
    hfrp_page_tbl u_page_tbl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .page_bytes (page_bytes_reg),
        .cmd        (pt_cmd),
        .stat       (pt_stat)
    );

    // Stored keys, addressed by page and slot
    hfrp_key_mem u_key_mem
    (
        .clk     (clk),
        .cmd     (km_cmd),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

// ===== rtl/hfrp_checker.sv =====
// Port-level checker for the heap file record placer, with its bind.
`default_nettype none

`include "heap_file_record_placer_defines.svh"

module hfrp_checker
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    input  wire logic                                req_stall,
    input  wire logic [hfrp_pkg::MODE_W-1:0]         mode,
    input  wire logic [hfrp_pkg::BYTES_W-1:0]        record_bytes,
    input  wire logic signed [hfrp_pkg::KEY_W-1:0]   key,
    input  wire logic                                rsp_valid,
    input  wire logic                                rsp_stall,
    input  wire logic                                ok,
    input  wire logic [hfrp_pkg::PAGE_FIELD_W-1:0]   page_index,
    input  wire logic [hfrp_pkg::SLOT_FIELD_W-1:0]   slot_index,
    input  wire logic [hfrp_pkg::COUNT_W-1:0]        count,
    input  wire logic                                last,
    input  wire logic                                page_bytes_we,
    input  wire logic [hfrp_pkg::BYTES_W-1:0]        page_bytes_wdata
);

    // Handshake: a stalled result beat stays and holds
    `HFRP_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(ok) && $stable(page_index) && $stable(slot_index) && $stable(count) && $stable(last), "result beat changed while stalled")

    // A taken request of a used mode busies the sequencer for at least the next cycle
    `HFRP_ASSERT_NXT(a_busy_after_req, req_valid && !req_stall && (mode == hfrp_pkg::MODE_INSERT || mode == hfrp_pkg::MODE_SEARCH || mode == hfrp_pkg::MODE_REPORT), req_stall, "request taken but block not busy")

    // A failed insert or missed search reports nothing else and ends the item
    `HFRP_ASSERT_NOW(a_fail_clean, rsp_valid && !ok, page_index == '0 && slot_index == '0 && count == '0 && last, "failed result carries stray fields")

    // Only report beats are not final, and they carry no page or slot
    `HFRP_ASSERT_NOW(a_report_fields, rsp_valid && !last, ok && page_index == '0 && slot_index == '0, "non-final beat is not a report beat")

endmodule

bind heap_file_record_placer hfrp_checker u_hfrp_checker (.*);

`default_nettype wire

// ===== sim/heap_file_record_placer_tb.sv =====
// Self-checking testbench for the heap file record placer: directed and random beats.
`default_nettype none

module heap_file_record_placer_tb;

    import hfrp_pkg::*;

    // Mode code that the block drops without a result
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RUN_LIMIT    = 2_000_000;  // cycles before the run is called hung
    localparam int HOLD_CYCLES  = 400;        // long result-side hold-off in the pressure phase
    localparam int PHASE_SETTLE = 20;         // quiet cycles before a page size write
    localparam int END_SETTLE   = 60;         // quiet cycles before the verdict

    // One request beat as the stimulus side sees it
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [BYTES_W-1:0] size;
        logic [KEY_W-1:0]   key;
    } request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      req_valid = 1'b0;
    logic                      req_stall;
    logic [MODE_W-1:0]         mode = '0;
    logic [BYTES_W-1:0]        record_bytes = '0;
    logic signed [KEY_W-1:0]   key = '0;

    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    logic                      ok;
    logic [PAGE_FIELD_W-1:0]   page_index;
    logic [SLOT_FIELD_W-1:0]   slot_index;
    logic [COUNT_W-1:0]        count;
    logic                      last;

    logic                      page_bytes_we = 1'b0;
    logic [BYTES_W-1:0]        page_bytes_wdata = '0;

    heap_file_record_placer i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .mode             (mode),
        .record_bytes     (record_bytes),
        .key              (key),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .ok               (ok),
        .page_index       (page_index),
        .slot_index       (slot_index),
        .count            (count),
        .last             (last),
        .page_bytes_we    (page_bytes_we),
        .page_bytes_wdata (page_bytes_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Heap file mirror: page size register, per-page room and record
    // count, stored keys and the number of open pages.
    // ------------------------------------------------------------------
    logic [BYTES_W-1:0]   cur_page_bytes = PAGE_BYTES_RESET;
    logic [BYTES_W-1:0]   room_left [MAX_PAGES];
    logic [COUNT_W-1:0]   records_on [MAX_PAGES];
    logic [KEY_BITS-1:0]  key_store [MAX_PAGES][MAX_SLOTS];
    logic [4:0]           pages_open = '0;

    beat_t    expected_beats [$];   // result beats still owed by the block, oldest first
    request_t pending_requests [$]; // request beats not yet offered
    logic [KEY_W-1:0] used_keys [$];// keys sent in inserts, reused by searches
    request_t offered;              // beat currently on the request port

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int cycles        = 0;
    int hold_left     = 0;
    logic hold_arm    = 1'b0;
    logic hold_done   = 1'b0;

    function automatic void owe_beat(input logic ok_b, input int pg, input int sl,
                                     input int cnt, input logic last_b);
        beat_t b;
        b.ok    = ok_b;
        b.page  = PAGE_FIELD_W'(pg);
        b.slot  = SLOT_FIELD_W'(sl);
        b.count = COUNT_W'(cnt);
        b.last  = last_b;
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    // Work out the result beats of one accepted request and advance the mirror.
    task automatic forecast_placement(input request_t r);
        logic [NEED_W-1:0] need;
        int hit;
        int p;
        int s;
        logic found;
        need  = {1'b0, r.size} + NEED_W'(SLOT_OVH_BYTES);
        hit   = -1;
        found = 1'b0;
        case (r.mode)
            MODE_INSERT:
            begin
                // First fit in page order
                for (p = 0; p < pages_open; p++)
                    if (hit < 0 && {1'b0, room_left[p]} >= need)
                        hit = p;
                // No page fits: append one unless the table is full; it stays
                // even if the record turns out too big for it.
                if (hit < 0 && pages_open < MAX_PAGES)
                begin
                    hit = pages_open;
                    room_left[hit]  = (cur_page_bytes >= PAGE_HDR_BYTES) ?
                                      cur_page_bytes - BYTES_W'(PAGE_HDR_BYTES) : '0;
                    records_on[hit] = '0;
                    pages_open++;
                end
                // A fit page with no free slot fails without looking further
                if (hit >= 0 && {1'b0, room_left[hit]} >= need && records_on[hit] < MAX_SLOTS)
                begin
                    key_store[hit][records_on[hit][SLOT_IDX_W-1:0]] = r.key;
                    owe_beat(1'b1, hit, int'(records_on[hit]), 0, 1'b1);
                    records_on[hit] = records_on[hit] + COUNT_W'(1);
                    room_left[hit]  = room_left[hit] - need[BYTES_W-1:0];
                end
                else
                    owe_beat(1'b0, 0, 0, 0, 1'b1);
            end
            MODE_SEARCH:
            begin
                for (p = 0; p < pages_open; p++)
                    for (s = 0; s < records_on[p]; s++)
                        if (!found && key_store[p][s] == r.key)
                        begin
                            found = 1'b1;
                            owe_beat(1'b1, p, s, 0, 1'b1);
                        end
                if (!found)
                    owe_beat(1'b0, 0, 0, 0, 1'b1);
            end
            MODE_REPORT:
            begin
                owe_beat(1'b1, 0, 0, int'(pages_open), pages_open == 0);
                for (p = 0; p < pages_open; p++)
                    owe_beat(1'b1, 0, 0, int'(records_on[p]), p + 1 == pages_open);
            end
            default: ; // unused mode: dropped, nothing owed
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_item(input logic [MODE_W-1:0] m,
                                       input logic [BYTES_W-1:0] sz,
                                       input logic [KEY_W-1:0] k);
        request_t r;
        r.mode = m;
        r.size = sz;
        r.key  = k;
        pending_requests.insert(pending_requests.size(), r);
        if (m == MODE_INSERT)
            used_keys.insert(used_keys.size(), k);
    endfunction

    // Mostly inserts and searches; searches favor keys sent in inserts, and a
    // small key pool makes duplicates so that the first match matters.
    function automatic request_t random_request();
        request_t r;
        int pick;
        int band;
        pick   = $urandom_range(99);
        r.size = BYTES_W'($urandom);
        r.key  = $urandom;
        if (pick < 50)
        begin
            r.mode = MODE_INSERT;
            band   = $urandom_range(9);
            if (band < 6)
                r.size = BYTES_W'($urandom_range(400));
            else if (band < 9)
                r.size = BYTES_W'($urandom_range(5000));
            if ($urandom_range(3) == 0)
                r.key = KEY_W'($urandom_range(15));
        end
        else if (pick < 85)
        begin
            r.mode = MODE_SEARCH;
            if (used_keys.size() != 0 && $urandom_range(9) < 6)
                r.key = used_keys[$urandom_range(used_keys.size() - 1)];
        end
        else if (pick < 95)
            r.mode = MODE_REPORT;
        else
            r.mode = MODE_UNUSED;
        return r;
    endfunction

    // Hold until every beat is offered, accepted and answered, then idle a while.
    task automatic drain(input int settle);
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || req_valid || expected_beats.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_page_bytes(input logic [BYTES_W-1:0] v);
        @(posedge clk);
        page_bytes_we    <= 1'b1;
        page_bytes_wdata <= v;
        @(posedge clk);
        page_bytes_we    <= 1'b0;
        cur_page_bytes = v;
    endtask

    // Queue a number of random beats (dropped modes not counted) and run them.
    task automatic run_random(input int n, input int idle, input int stall);
        request_t r;
        int made;
        made          = 0;
        send_idle_pct = idle;
        stall_pct     = stall;
        while (made < n)
        begin
            r = random_request();
            queue_item(r.mode, r.size, r.key);
            if (r.mode != MODE_UNUSED)
                made++;
        end
        drain(PHASE_SETTLE);
    endtask

    // ------------------------------------------------------------------
    // Request driver: offer the next pending beat, hold it while stalled,
    // and forecast its results at the edge that accepts it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                forecast_placement(offered);
            if (!req_valid || !req_stall)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered       = pending_requests.pop_front();
                    req_valid    <= 1'b1;
                    mode         <= offered.mode;
                    record_bytes <= offered.size;
                    key          <= offered.key;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: check each accepted beat against the oldest one owed,
    // then pick the stall for the next cycle.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [COUNT_W-1:0] got,
                                 input logic [COUNT_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch("result beat with nothing owed");
                else
                begin
                    want = expected_beats.pop_front();
                    compare_field("ok", COUNT_W'(ok), COUNT_W'(want.ok));
                    compare_field("page_index", COUNT_W'(page_index), COUNT_W'(want.page));
                    compare_field("slot_index", COUNT_W'(slot_index), COUNT_W'(want.slot));
                    compare_field("count", count, want.count);
                    compare_field("last", COUNT_W'(last), COUNT_W'(want.last));
                end
            end
            rsp_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
        end
    end

    // Long result-side hold-off, fired once when armed; it lets the output
    // register fill so the block has to stall its request side.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Watchdog: a lost result beat or a wedged handshake ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset page size of 4096 bytes.
        queue_item(MODE_REPORT, 16'h0000, 32'h0000_0000);     // empty file: one beat
        queue_item(MODE_SEARCH, 16'h0000, 32'h0000_0000);     // search with no pages
        queue_item(MODE_INSERT, 16'h0000, 32'h8000_0000);     // smallest record, page 0
        queue_item(MODE_INSERT, 16'hFFFF, 32'h7FFF_FFFF);     // too big: page 1 kept, fails
        queue_item(MODE_INSERT, 16'd4076, 32'hFFFF_FFFF);     // exact fill of page 1
        queue_item(MODE_INSERT, 16'd4072, 32'h0000_0001);     // exact fill of page 0
        queue_item(MODE_SEARCH, 16'hFFFF, 32'h8000_0000);
        queue_item(MODE_SEARCH, 16'h0000, 32'hFFFF_FFFF);
        queue_item(MODE_SEARCH, 16'h5555, 32'h0000_0001);
        queue_item(MODE_SEARCH, 16'hAAAA, 32'h7FFF_FFFF);     // failed insert left no key
        queue_item(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);     // dropped
        queue_item(MODE_REPORT, 16'hFFFF, 32'hFFFF_FFFF);
        drain(PHASE_SETTLE);

        // Page smaller than its header: appended with no room at all.
        write_page_bytes(16'd12);
        queue_item(MODE_INSERT, 16'h0000, 32'h0000_0002);
        drain(PHASE_SETTLE);

        // Smallest legal page: room for one empty record; duplicate keys.
        write_page_bytes(16'd20);
        queue_item(MODE_INSERT, 16'h0000, 32'h0000_0003);
        queue_item(MODE_INSERT, 16'h0000, 32'h0000_0003);
        queue_item(MODE_SEARCH, 16'h0000, 32'h0000_0003);     // first match wins
        queue_item(MODE_REPORT, 16'h0000, 32'h0000_0000);
        drain(PHASE_SETTLE);

        // Random phases, each at its own page size and idling mix.
        write_page_bytes(16'hFFFF);
        run_random(16, 0, 0);      // no idling
        write_page_bytes(16'd600);
        run_random(12, 87, 0);     // sender mostly idle; appends soon fill the table
        write_page_bytes(16'd300);
        run_random(12, 0, 87);     // receiver mostly stalling
        write_page_bytes(16'd1000);
        run_random(12, 7, 7);      // light idling on both sides

        // Pressure: hold off the result side while requests keep coming.
        write_page_bytes(16'd2000);
        hold_arm = 1'b1;
        run_random(12, 0, 0);

        // Slot exhaustion last: once the first fit page runs out of slots it
        // fails every small insert, so drive it there only at the end.
        write_page_bytes(16'd4096);
        send_idle_pct = 7;
        stall_pct     = 7;
        for (i = 0; i < 70; i++)
            queue_item(MODE_INSERT, 16'h0000, $urandom);
        for (i = 0; i < 8; i++)
            queue_item(MODE_SEARCH, 16'h0000, used_keys[$urandom_range(used_keys.size() - 1)]);
        queue_item(MODE_REPORT, 16'h0000, 32'h0000_0000);
        drain(END_SETTLE);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
